// File: src/scq_pkg.sv
// Package for the serial command line queue: control word, step codes, command text.
package scq_pkg;

	localparam int UPC_W = 4;
	localparam int CMD_IDX_W = 5;
	localparam int LEFT_LEN = 17;
	localparam int RIGHT_LEN = 18;

	localparam logic [LEFT_LEN*8-1:0] LEFT_STR = {"led_shift_", "left", "_on"};
	localparam logic [RIGHT_LEN*8-1:0] RIGHT_STR = {"led_shift_", "right", "_on"};

	localparam logic [7:0] CHAR_LF = 8'h0a;
	localparam logic [7:0] CHAR_CR = 8'h0d;
	localparam logic [7:0] CHAR_NUL = 8'h00;

	// Microprogram step addresses
	localparam logic [UPC_W-1:0] STEP_WAIT = 4'd0;
	localparam logic [UPC_W-1:0] STEP_BYTE = 4'd1;
	localparam logic [UPC_W-1:0] STEP_POLL = 4'd2;
	localparam logic [UPC_W-1:0] STEP_CMPL = 4'd3;
	localparam logic [UPC_W-1:0] STEP_HITL = 4'd4;
	localparam logic [UPC_W-1:0] STEP_STARTR = 4'd5;
	localparam logic [UPC_W-1:0] STEP_CMPR = 4'd6;
	localparam logic [UPC_W-1:0] STEP_HITR = 4'd7;
	localparam logic [UPC_W-1:0] STEP_MISS = 4'd8;
	localparam logic [UPC_W-1:0] STEP_EMPTY = 4'd9;

	typedef enum logic [2:0] {
		COND_SEQ   = 3'd0,
		COND_JMP   = 3'd1,
		COND_IN    = 3'd2,
		COND_EMPTY = 3'd3,
		COND_CMP   = 3'd4
	} cond_t;

	localparam logic [1:0] SEEN_NONE = 2'd0;
	localparam logic [1:0] SEEN_LEFT = 2'd1;
	localparam logic [1:0] SEEN_RIGHT = 2'd2;

	typedef struct packed {
		cond_t            cond;
		logic [UPC_W-1:0] target;
		logic             in_ready;
		logic             do_byte;
		logic             rd_start;
		logic             rd_next;
		logic             sel_right;
		logic             take;
		logic             hit_left;
		logic             hit_right;
		logic             out_load;
	} ctrl_t;

	typedef struct packed {
		logic empty;
		logic mismatch;
		logic last;
		logic dropped;
	} status_t;

	function automatic logic [7:0] cmd_char(input logic sel_right,
		input logic [CMD_IDX_W-1:0] idx);
		logic [7:0] c;
		c = CHAR_NUL;
		if (sel_right) begin
			if (int'(idx) < RIGHT_LEN)
				c = RIGHT_STR[(RIGHT_LEN - 1 - int'(idx))*8 +: 8];
		end else begin
			if (int'(idx) < LEFT_LEN)
				c = LEFT_STR[(LEFT_LEN - 1 - int'(idx))*8 +: 8];
		end
		return c;
	endfunction

endpackage

// File: src/scq_rom.sv
// Microprogram table: one control word per sequencer step.
module scq_rom (
	input  logic [scq_pkg::UPC_W-1:0] upc,
	output scq_pkg::ctrl_t            ctrl
);

	always_comb begin
		ctrl = '0;
		ctrl.cond = scq_pkg::COND_JMP;
		ctrl.target = scq_pkg::STEP_WAIT;
		case (upc)
			scq_pkg::STEP_WAIT: begin
				ctrl.cond = scq_pkg::COND_IN;
				ctrl.target = scq_pkg::STEP_POLL;
				ctrl.in_ready = 1'b1;
			end
			scq_pkg::STEP_BYTE: begin
				ctrl.do_byte = 1'b1;
				ctrl.out_load = 1'b1;
			end
			scq_pkg::STEP_POLL: begin
				ctrl.cond = scq_pkg::COND_EMPTY;
				ctrl.target = scq_pkg::STEP_EMPTY;
				ctrl.rd_start = 1'b1;
			end
			scq_pkg::STEP_CMPL: begin
				ctrl.cond = scq_pkg::COND_CMP;
				ctrl.target = scq_pkg::STEP_STARTR;
				ctrl.rd_next = 1'b1;
			end
			scq_pkg::STEP_HITL: begin
				ctrl.take = 1'b1;
				ctrl.hit_left = 1'b1;
				ctrl.out_load = 1'b1;
			end
			scq_pkg::STEP_STARTR: begin
				ctrl.cond = scq_pkg::COND_SEQ;
				ctrl.rd_start = 1'b1;
				ctrl.sel_right = 1'b1;
			end
			scq_pkg::STEP_CMPR: begin
				ctrl.cond = scq_pkg::COND_CMP;
				ctrl.target = scq_pkg::STEP_MISS;
				ctrl.rd_next = 1'b1;
			end
			scq_pkg::STEP_HITR: begin
				ctrl.take = 1'b1;
				ctrl.hit_right = 1'b1;
				ctrl.out_load = 1'b1;
			end
			scq_pkg::STEP_MISS: begin
				ctrl.take = 1'b1;
				ctrl.out_load = 1'b1;
			end
			scq_pkg::STEP_EMPTY: begin
				ctrl.out_load = 1'b1;
			end
			default: begin
				ctrl.cond = scq_pkg::COND_JMP;
				ctrl.target = scq_pkg::STEP_WAIT;
			end
		endcase
	end

endmodule

// File: src/scq_datapath.sv
// Datapath: line store, ring pointers, character index, mode and command compare.
module scq_datapath #(
	parameter int LINE_SLOTS = 8,
	parameter int LINE_LEN = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_accept,
	input  logic [7:0]           in_byte,
	input  logic                 en,
	input  scq_pkg::ctrl_t       ctrl,
	output scq_pkg::status_t     status,
	output logic                 mode
);

	localparam int SW = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;
	localparam int IW = $clog2(LINE_LEN);
	localparam int DEPTH = LINE_SLOTS * (2 ** IW);
	localparam logic [SW-1:0] SLOT_LAST = SW'(LINE_SLOTS - 1);
	localparam logic [IW-1:0] IDX_LAST = IW'(LINE_LEN - 1);

	logic [7:0]                    mem [DEPTH];
	logic [7:0]                    byte_q;
	logic [7:0]                    rdata_q;
	logic [SW-1:0]                 head_q, tail_q, head_inc, tail_inc;
	logic [IW-1:0]                 char_q;
	logic [scq_pkg::CMD_IDX_W-1:0] k_q;
	logic                          sel_q;
	logic                          mode_q;
	logic                          full, eol, line_full, wr_en;
	logic [IW-1:0]                 rd_idx;
	logic [SW+IW-1:0]              wr_addr, rd_addr;
	logic [7:0]                    wr_data;

	assign head_inc = (head_q == SLOT_LAST) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == SLOT_LAST) ? '0 : tail_q + 1'b1;
	assign full = (tail_inc == head_q);
	assign eol = (byte_q == scq_pkg::CHAR_LF) || (byte_q == scq_pkg::CHAR_CR);
	assign line_full = (char_q >= IDX_LAST);
	assign wr_en = en && ctrl.do_byte && !full && (eol || !line_full);
	assign wr_data = eol ? scq_pkg::CHAR_NUL : byte_q;
	assign wr_addr = {tail_q, char_q};
	assign rd_idx = ctrl.rd_start ? '0 : IW'(k_q);
	assign rd_addr = {head_q, rd_idx};

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rdata_q <= mem[rd_addr];
		if (in_accept)
			byte_q <= in_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			char_q <= '0;
			mode_q <= 1'b0;
			k_q <= '0;
			sel_q <= 1'b0;
		end else if (en) begin
			if (ctrl.do_byte && !full) begin
				if (eol) begin
					char_q <= '0;
					tail_q <= tail_inc;
				end else if (!line_full) begin
					char_q <= char_q + 1'b1;
				end
			end
			if (ctrl.take)
				head_q <= head_inc;
			if (ctrl.hit_left)
				mode_q <= 1'b0;
			else if (ctrl.hit_right)
				mode_q <= 1'b1;
			// start a compare pass: address 0 goes out now, count on from 1
			if (ctrl.rd_start) begin
				k_q <= scq_pkg::CMD_IDX_W'(1);
				sel_q <= ctrl.sel_right;
			end else if (ctrl.rd_next) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// rdata_q holds the character at k_q - 1
	assign status.empty = (head_q == tail_q);
	assign status.mismatch = (rdata_q != scq_pkg::cmd_char(sel_q, k_q - 1'b1));
	assign status.last = sel_q ? (k_q == scq_pkg::CMD_IDX_W'(scq_pkg::RIGHT_LEN))
	                           : (k_q == scq_pkg::CMD_IDX_W'(scq_pkg::LEFT_LEN));
	assign status.dropped = full || (!eol && line_full);
	assign mode = mode_q;

endmodule

// File: src/serial_command_line_queue_core.sv
// Top level: microprogram sequencer, stream ports and result register.
// A received byte occupies the sequencer for the accepting step and one byte step, which
// registers its result. A poll on an empty ring passes the accepting step, the poll step
// and the empty step, which registers its result. A poll that takes a line runs the
// compare loop, which reads one stored character per cycle from the line store against
// the left command (17 characters) and then the right command (18 characters); the two
// commands part at their eleventh character, so at most one of the two passes runs long.
// Bytes are written into slot tail at the current character index; a newline or carriage
// return stores a zero terminator and closes the slot. The line store needs no clearing
// after reset. A new transaction is taken only while the sequencer waits at its first
// step, and a result step holds while the previous result has not been taken.
module serial_command_line_queue_core #(
	parameter int LINE_SLOTS = 8,
	parameter int LINE_LEN = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	input  logic       s_tuser,   // [0] kind
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [0] mode, [1] line_taken, [3:2] command_seen,
	                              // [4] byte_dropped, [7:5] zero
);

	logic [scq_pkg::UPC_W-1:0] upc_q, upc_next;
	scq_pkg::ctrl_t            ctrl;
	scq_pkg::status_t          status;
	logic                      in_acc, stall, en, mode_now;
	logic                      m_tvalid_q;
	logic [7:0]                m_tdata_q;
	logic                      res_mode, res_dropped;
	logic [1:0]                res_seen;

	scq_rom u_rom (
		.upc  (upc_q),
		.ctrl (ctrl)
	);

	scq_datapath #(
		.LINE_SLOTS (LINE_SLOTS),
		.LINE_LEN   (LINE_LEN)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_acc),
		.in_byte   (s_tdata),
		.en        (en),
		.ctrl      (ctrl),
		.status    (status),
		.mode      (mode_now)
	);

	assign s_tready = ctrl.in_ready;
	assign in_acc = s_tvalid && s_tready;
	// hold a result step while the last transaction still waits on the output
	assign stall = ctrl.out_load && m_tvalid_q && !m_tready;
	assign en = !stall;

	always_comb begin
		upc_next = upc_q + 1'b1;
		case (ctrl.cond)
			scq_pkg::COND_SEQ:   upc_next = upc_q + 1'b1;
			scq_pkg::COND_JMP:   upc_next = ctrl.target;
			scq_pkg::COND_IN: begin
				if (!in_acc)
					upc_next = upc_q;
				else if (s_tuser)
					upc_next = ctrl.target;
				else
					upc_next = upc_q + 1'b1;
			end
			scq_pkg::COND_EMPTY: upc_next = status.empty ? ctrl.target : upc_q + 1'b1;
			scq_pkg::COND_CMP: begin
				if (status.mismatch)
					upc_next = ctrl.target;
				else if (status.last)
					upc_next = upc_q + 1'b1;
				else
					upc_next = upc_q;
			end
			default:             upc_next = scq_pkg::STEP_WAIT;
		endcase
	end

	assign res_mode = ctrl.hit_left ? 1'b0 : (ctrl.hit_right ? 1'b1 : mode_now);
	assign res_seen = ctrl.hit_left ? scq_pkg::SEEN_LEFT
	                : (ctrl.hit_right ? scq_pkg::SEEN_RIGHT : scq_pkg::SEEN_NONE);
	assign res_dropped = ctrl.do_byte && status.dropped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= scq_pkg::STEP_WAIT;
			m_tvalid_q <= 1'b0;
		end else begin
			if (en)
				upc_q <= upc_next;
			if (ctrl.out_load && en)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load && en)
			m_tdata_q <= {3'b000, res_dropped, res_seen, ctrl.take, res_mode};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule

// File: dv/tb_serial_command_line_queue_core.sv
// Self-checking testbench for serial_command_line_queue_core: byte and poll stream vs predictor.
module tb_serial_command_line_queue_core;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_SLOTS = 8;
	localparam int LINE_LEN = 32;
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_POLL = 1'b1;
	localparam logic MODE_LEFT = 1'b0;
	localparam logic MODE_RIGHT = 1'b1;
	localparam int RANDOM_ITEMS = 950;
	localparam int DRAIN_EVERY = 250;
	localparam int HOLD_AT = 400;
	localparam int LONG_HOLD = 600;
	localparam int TAIL_CYCLES = 60;

	typedef struct packed {
		logic       byte_dropped;
		logic [1:0] command_seen;
		logic       line_taken;
		logic       mode;
	} scq_result_t;

	typedef struct packed {
		logic       drain;
		logic       kind;
		logic [7:0] rx;
	} scq_item_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'd0;
	logic       s_tuser = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;

	serial_command_line_queue_core #(
		.LINE_SLOTS(LINE_SLOTS),
		.LINE_LEN(LINE_LEN)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	string left_txt = {"led_shift_", "left", "_on"};
	string right_txt = {"led_shift_", "right", "_on"};

	// predictor state
	logic [7:0] line_mem [LINE_SLOTS][LINE_LEN];
	int         wr_slot = 0;
	int         rd_slot = 0;
	int         col = 0;
	logic       mode_q = MODE_LEFT;

	scq_item_t   pending_q[$];
	scq_result_t result_q[$];
	logic [7:0]  line_buf[$];
	bit          drain_next = 0;

	int errors = 0;
	int n_sent = 0;
	int n_results = 0;
	int n_taken = 0;
	int n_left = 0;
	int n_right = 0;
	int n_dropped = 0;
	int tx_wait = 0;
	int tx_calm = 0;
	int rx_stall = 0;
	int rx_calm = 0;
	int hold_left = 0;
	bit hold_done = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(30, 80);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 80);
	endfunction

	function automatic bit line_starts(input int slot, input string cmd);
		for (int k = 0; k < cmd.len(); k++)
			if (line_mem[slot][k] != cmd[k])
				return 0;
		return 1;
	endfunction

	function automatic scq_result_t predict_step(input logic kind, input logic [7:0] rx);
		scq_result_t r;
		r = '0;
		if (kind == KIND_BYTE) begin
			if ((wr_slot + 1) % LINE_SLOTS == rd_slot) begin
				r.byte_dropped = 1'b1;
			end else if (rx == scq_pkg::CHAR_LF || rx == scq_pkg::CHAR_CR) begin
				line_mem[wr_slot][col] = scq_pkg::CHAR_NUL;
				col = 0;
				wr_slot = (wr_slot + 1) % LINE_SLOTS;
			end else if (col >= LINE_LEN - 1) begin
				r.byte_dropped = 1'b1;
			end else begin
				line_mem[wr_slot][col] = rx;
				col++;
			end
		end else if (rd_slot != wr_slot) begin
			r.line_taken = 1'b1;
			if (line_starts(rd_slot, left_txt)) begin
				mode_q = MODE_LEFT;
				r.command_seen = scq_pkg::SEEN_LEFT;
			end else if (line_starts(rd_slot, right_txt)) begin
				mode_q = MODE_RIGHT;
				r.command_seen = scq_pkg::SEEN_RIGHT;
			end
			rd_slot = (rd_slot + 1) % LINE_SLOTS;
		end
		r.mode = mode_q;
		return r;
	endfunction

	function automatic logic [7:0] data_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == scq_pkg::CHAR_LF || b == scq_pkg::CHAR_CR);
		return b;
	endfunction

	task automatic add_item(input logic kind, input logic [7:0] rx);
		scq_item_t it;
		it.drain = drain_next;
		it.kind = kind;
		it.rx = rx;
		drain_next = 0;
		pending_q.push_back(it);
	endtask

	task automatic add_poll();
		add_item(KIND_POLL, 8'($urandom_range(0, 255)));
	endtask

	task automatic append_text(input string s);
		for (int k = 0; k < s.len(); k++)
			line_buf.push_back(s[k]);
	endtask

	// one line of mostly command-like text, usually closed by LF or CR
	task automatic add_random_line();
		string cmd;
		int sel, n, pos;
		logic [7:0] b;
		line_buf.delete();
		sel = $urandom_range(0, 99);
		cmd = ($urandom_range(0, 1) == 0) ? left_txt : right_txt;
		if (sel < 18) begin
			append_text(left_txt);
		end else if (sel < 36) begin
			append_text(right_txt);
		end else if (sel < 56) begin
			append_text(cmd);
			repeat ($urandom_range(1, 6)) line_buf.push_back(data_byte());
		end else if (sel < 64) begin
			n = $urandom_range(0, cmd.len() - 1);
			for (int k = 0; k < n; k++)
				line_buf.push_back(cmd[k]);
		end else if (sel < 74) begin
			append_text(cmd);
			pos = $urandom_range(0, cmd.len() - 1);
			do
				b = data_byte();
			while (b == line_buf[pos]);
			line_buf[pos] = b;
		end else if (sel < 80) begin
			append_text(cmd);
			line_buf.insert($urandom_range(0, cmd.len()), scq_pkg::CHAR_NUL);
		end else if (sel < 88) begin
			repeat ($urandom_range(0, 12)) line_buf.push_back(data_byte());
		end else if (sel < 96) begin
			// long or overlong: tail is dropped once the slot is full
			n = $urandom_range(29, 38);
			if ($urandom_range(0, 1) == 0)
				append_text(cmd);
			while (line_buf.size() < n)
				line_buf.push_back(data_byte());
		end
		foreach (line_buf[k])
			add_item(KIND_BYTE, line_buf[k]);
		if ($urandom_range(0, 24) != 0)
			add_item(KIND_BYTE,
				($urandom_range(0, 1) == 0) ? scq_pkg::CHAR_LF : scq_pkg::CHAR_CR);
	endtask

	task automatic build_stimulus();
		int r, next_drain;
		// empty poll, zero and all-ones bytes, CR close, poll with miss
		add_item(KIND_POLL, 8'hff);
		add_item(KIND_BYTE, scq_pkg::CHAR_NUL);
		add_item(KIND_BYTE, 8'hff);
		add_item(KIND_BYTE, "l");
		add_item(KIND_BYTE, scq_pkg::CHAR_CR);
		add_item(KIND_POLL, 8'h00);
		// fill the ring with empty lines, then bytes and terminators are dropped
		repeat (LINE_SLOTS - 1) add_item(KIND_BYTE, scq_pkg::CHAR_LF);
		add_item(KIND_BYTE, "a");
		add_item(KIND_BYTE, scq_pkg::CHAR_LF);
		add_item(KIND_BYTE, scq_pkg::CHAR_CR);
		add_item(KIND_POLL, 8'h5a);
		add_item(KIND_POLL, 8'ha5);
		drain_next = 1;
		next_drain = pending_q.size() + DRAIN_EVERY;
		while (pending_q.size() < 18 + RANDOM_ITEMS) begin
			if (pending_q.size() >= next_drain) begin
				drain_next = 1;
				next_drain += DRAIN_EVERY;
			end
			r = $urandom_range(0, 99);
			if (r < 6) begin
				repeat ($urandom_range(6, 9)) add_random_line();
				repeat ($urandom_range(4, 9)) add_poll();
			end else if (r < 14) begin
				repeat ($urandom_range(1, 4))
					add_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
			end else begin
				add_random_line();
				repeat ($urandom_range(0, 2)) add_poll();
			end
		end
	endtask

	// driver: offer pending transactions, predict each accepted one
	always @(posedge clk or negedge arst_n) begin
		scq_result_t exp_r;
		scq_item_t it;
		logic valid_n;
		logic [7:0] data_n;
		logic kind_n;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'd0;
			s_tuser <= KIND_BYTE;
		end else begin
			valid_n = s_tvalid;
			data_n = s_tdata;
			kind_n = s_tuser;
			if (s_tvalid && s_tready) begin
				exp_r = predict_step(s_tuser, s_tdata);
				result_q.push_back(exp_r);
				n_sent++;
				n_taken += exp_r.line_taken;
				n_left += (exp_r.command_seen == scq_pkg::SEEN_LEFT);
				n_right += (exp_r.command_seen == scq_pkg::SEEN_RIGHT);
				n_dropped += exp_r.byte_dropped;
				tx_wait = pick_gap(tx_calm);
				valid_n = 1'b0;
			end
			if (!valid_n) begin
				if (tx_wait > 0) begin
					tx_wait--;
				end else if (pending_q.size() > 0 &&
						!(pending_q[0].drain && result_q.size() != 0)) begin
					it = pending_q.pop_front();
					valid_n = 1'b1;
					data_n = it.rx;
					kind_n = it.kind;
				end
			end
			s_tvalid <= valid_n;
			s_tdata <= data_n;
			s_tuser <= kind_n;
		end
	end

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// monitor: check results, vary m_tready, one long hold-off
	always @(posedge clk or negedge arst_n) begin
		scq_result_t exp_r, got_r;
		logic rdy;
		int g;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_r = m_tdata[4:0];
				if (result_q.size() == 0) begin
					$display("%0t: result with none expected, expected none, actual %02h",
						$time, m_tdata);
					errors++;
				end else begin
					exp_r = result_q.pop_front();
					check_field("mode", exp_r.mode, got_r.mode);
					check_field("line_taken", exp_r.line_taken, got_r.line_taken);
					check_field("command_seen", exp_r.command_seen, got_r.command_seen);
					check_field("byte_dropped", exp_r.byte_dropped, got_r.byte_dropped);
					check_field("pad bits", 0, m_tdata[7:5]);
				end
				n_results++;
			end
			rdy = 1'b1;
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (!hold_done && n_results >= HOLD_AT) begin
				hold_done = 1;
				hold_left = LONG_HOLD - 1;
				rdy = 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall--;
				rdy = 1'b0;
			end else if (m_tvalid && m_tready) begin
				g = pick_gap(rx_calm);
				if (g > 0) begin
					rx_stall = g - 1;
					rdy = 1'b0;
				end
			end
			m_tready <= rdy;
		end
	end

	initial begin
		build_stimulus();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_q.size() != 0 || s_tvalid || result_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Ran %0d transactions: %0d lines taken, %0d left and %0d right commands,",
			n_sent, n_taken, n_left, n_right);
		$display("%0d bytes dropped on full ring or full line, one long output hold-off.",
			n_dropped);
		if (errors == 0 && result_q.size() == 0)
			$display("serial_command_line_queue_core: match");
		else
			$display("serial_command_line_queue_core: mismatch");
		$finish;
	end

	initial begin
		#15_000_000;
		$display("Timeout with %0d results outstanding", result_q.size());
		$display("serial_command_line_queue_core: mismatch");
		$finish;
	end

endmodule

// File: sim.f
src/scq_pkg.sv
src/scq_rom.sv
src/scq_datapath.sv
src/serial_command_line_queue_core.sv
dv/tb_serial_command_line_queue_core.sv
